### rtl/pgps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pgps_pkg
// Shared types and constants for the polar goto-pose steering block.
// -----------------------------------------------------------------------------
package pgps_pkg;

  // register indexes
  localparam logic [2:0] RegGoalX     = 3'd0;
  localparam logic [2:0] RegGoalY     = 3'd1;
  localparam logic [2:0] RegGoalHead  = 3'd2;
  localparam logic [2:0] RegGainDist  = 3'd3;
  localparam logic [2:0] RegGainBear  = 3'd4;
  localparam logic [2:0] RegGainFinal = 3'd5;
  localparam logic [2:0] RegMaxSpeed  = 3'd6;
  localparam logic [2:0] RegArrive    = 3'd7;

  localparam int unsigned CordicIters = 28;
  localparam int unsigned QueueDepth  = 2;

  localparam logic signed [21:0] AngMax = 22'sd2097151;
  localparam logic signed [21:0] AngMin = -22'sd2097152;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic               arrived;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic        [49:0] sum_sq;
    logic signed [15:0] heading;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_RUN, BK_MUL, BK_DIV, BK_OUT
  } bk_state_e;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/polar_goto_pose_steering_top.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// polar_goto_pose_steering_top
// Polar-coordinate goto-pose steering: pose in, speed and turn rate out.
// -----------------------------------------------------------------------------
// the back end works on one queued item at a time and takes no new one until
// it is through; its pace is set by the shared cordic/root run and the
// bit-serial divider in the back end, which arrived items skip
// front and back are parted by a two-entry queue; results are strobed once,
// the receiver cannot stall
// reset: async active low, registers take their reset values, queue empties
module polar_goto_pose_steering_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [23:0]  pos_x_i,
  input  wire logic signed [23:0]  pos_y_i,
  input  wire logic signed [15:0]  heading_i,
  output logic                     done_o,
  output logic signed [18:0]       linear_speed_o,
  output logic signed [21:0]       angular_rate_o,
  output logic                     arrived_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);

  logic signed [23:0] goal_x_q, goal_y_q;
  logic signed [15:0] goal_head_q;
  logic signed [19:0] k_rho_q, k_alpha_q, k_beta_q;
  logic        [17:0] max_speed_q;
  logic        [22:0] arrive_q;

  // items in the front pipe, reserved against queue space
  logic [1:0] infl_q;
  logic       accept_w, push_w, pop_w, q_valid_w, bk_idle_w;
  logic [$clog2(pgps_pkg::QueueDepth+1)-1:0] q_cnt_w;
  pgps_pkg::item_t push_item_w, q_item_w;

  // configuration registers, written only with nothing in flight
  assign cfg_ready_o = bk_idle_w && (infl_q == '0) && (q_cnt_w == '0) && !start;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      goal_head_q <= '0;
      k_rho_q     <= 20'sd19661;
      k_alpha_q   <= 20'sd52429;
      k_beta_q    <= -20'sd9830;
      max_speed_q <= 18'd19661;
      arrive_q    <= 23'd6554;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pgps_pkg::RegGoalX:     goal_x_q    <= cfg_data_i[23:0];
        pgps_pkg::RegGoalY:     goal_y_q    <= cfg_data_i[23:0];
        pgps_pkg::RegGoalHead:  goal_head_q <= cfg_data_i[15:0];
        pgps_pkg::RegGainDist:  k_rho_q     <= cfg_data_i[19:0];
        pgps_pkg::RegGainBear:  k_alpha_q   <= cfg_data_i[19:0];
        pgps_pkg::RegGainFinal: k_beta_q    <= cfg_data_i[19:0];
        pgps_pkg::RegMaxSpeed:  max_speed_q <= cfg_data_i[17:0];
        pgps_pkg::RegArrive:    arrive_q    <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  assign accept_w = start && !busy;
  assign busy     = (32'(infl_q) + 32'(q_cnt_w)) >= pgps_pkg::QueueDepth;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infl_q <= '0;
    end else begin
      infl_q <= infl_q + 2'(accept_w) - 2'(push_w);
    end
  end

  pgps_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (accept_w),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .heading_i       (heading_i),
    .goal_x_i        (goal_x_q),
    .goal_y_i        (goal_y_q),
    .arrive_radius_i (arrive_q),
    .out_ready_i     (1'b1),
    .out_valid_o     (push_w),
    .out_item_o      (push_item_w)
  );

  pgps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_w),
    .push_item_i (push_item_w),
    .pop_i       (pop_w),
    .valid_o     (q_valid_w),
    .item_o      (q_item_w),
    .count_o     (q_cnt_w)
  );

  pgps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (q_valid_w),
    .in_item_i       (q_item_w),
    .pop_o           (pop_w),
    .idle_o          (bk_idle_w),
    .goal_heading_i  (goal_head_q),
    .gain_distance_i (k_rho_q),
    .gain_bearing_i  (k_alpha_q),
    .gain_final_i    (k_beta_q),
    .max_speed_i     (max_speed_q),
    .done_o          (done_o),
    .linear_speed_o  (linear_speed_o),
    .angular_rate_o  (angular_rate_o),
    .arrived_o       (arrived_o)
  );

endmodule
`default_nettype wire

### rtl/pgps_front.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pgps_front
// Takes a pose, forms the goal offset and squared distance, tests arrival.
// -----------------------------------------------------------------------------
module pgps_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic signed [23:0]    pos_x_i,
  input  wire logic signed [23:0]    pos_y_i,
  input  wire logic signed [15:0]    heading_i,
  input  wire logic signed [23:0]    goal_x_i,
  input  wire logic signed [23:0]    goal_y_i,
  input  wire logic        [22:0]    arrive_radius_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output pgps_pkg::item_t            out_item_o
);

  // stage one: offsets
  logic               s1_valid_q;
  logic signed [24:0] dx_q, dy_q;
  logic signed [15:0] hd1_q;
  // stage two: squares
  logic               s2_valid_q;
  logic        [49:0] sqx_q, sqy_q, r2_q;
  logic signed [24:0] dx2_q, dy2_q;
  logic signed [15:0] hd2_q;

  // offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      dx_q  <= 25'(goal_x_i) - 25'(pos_x_i);
      dy_q  <= 25'(goal_y_i) - 25'(pos_y_i);
      hd1_q <= heading_i;
    end
  end

  // squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      sqx_q <= 50'(dx_q * dx_q);
      sqy_q <= 50'(dy_q * dy_q);
      r2_q  <= 50'({27'd0, arrive_radius_i} * {27'd0, arrive_radius_i});
      dx2_q <= dx_q;
      dy2_q <= dy_q;
      hd2_q <= hd1_q;
    end
  end

  // sum and arrival compare; queue has room by construction of start gating
  logic [49:0] sum_w;
  assign sum_w = sqx_q + sqy_q;
  assign out_valid_o = s2_valid_q && out_ready_i;
  always_comb begin
    out_item_o.arrived = (sum_w <= r2_q);
    out_item_o.dx      = dx2_q;
    out_item_o.dy      = dy2_q;
    out_item_o.sum_sq  = sum_w;
    out_item_o.heading = hd2_q;
  end

endmodule
`default_nettype wire

### rtl/pgps_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pgps_queue
// Short queue between the front and the back.
// -----------------------------------------------------------------------------
module pgps_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire pgps_pkg::item_t  push_item_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output pgps_pkg::item_t       item_o,
  output logic [$clog2(pgps_pkg::QueueDepth+1)-1:0] count_o
);

  localparam int unsigned AW = $clog2(pgps_pkg::QueueDepth);
  localparam int unsigned CW = $clog2(pgps_pkg::QueueDepth+1);

  pgps_pkg::item_t mem_q [pgps_pkg::QueueDepth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop_i)  rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_item_i;
  end

  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule
`default_nettype wire

### rtl/pgps_back.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pgps_back
// Per queued item: unless arrived, square root, CORDIC bearing and divide; result.
// -----------------------------------------------------------------------------
module pgps_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire pgps_pkg::item_t       in_item_i,
  output logic                       pop_o,
  output logic                       idle_o,
  input  wire logic signed [15:0]    goal_heading_i,
  input  wire logic signed [19:0]    gain_distance_i,
  input  wire logic signed [19:0]    gain_bearing_i,
  input  wire logic signed [19:0]    gain_final_i,
  input  wire logic        [17:0]    max_speed_i,
  output logic                       done_o,
  output logic signed [18:0]         linear_speed_o,
  output logic signed [21:0]         angular_rate_o,
  output logic                       arrived_o
);

  pgps_pkg::bk_state_e state_q, state_d;

  logic [5:0]  cnt_q;
  // square root
  logic [49:0] rem_q;
  logic [49:0] root_q;
  logic [51:0] bit_q;
  // cordic
  logic signed [58:0] cx_q, cy_q;
  logic        [31:0] cz_q;
  logic signed [15:0] hd_q;
  // products and division
  logic signed [38:0] n_q;
  logic        [43:0] nra_q;
  logic        [63:0] m_q;
  logic        [45:0] d_q;
  logic        [63:0] num_q;
  logic        [63:0] quo_q;
  logic        [64:0] prem_q;
  logic               neg_q;

  // square root step
  logic [51:0] trial_w;
  assign trial_w = {2'd0, root_q} + bit_q;

  // cordic step
  logic signed [58:0] xs_w, ys_w;
  assign xs_w = cx_q >>> cnt_q;
  assign ys_w = cy_q >>> cnt_q;

  // angle terms
  logic [15:0]        th_w;
  logic signed [15:0] alpha_w, beta_w;
  assign th_w    = 16'((cz_q + 32'h8000) >> 16);
  assign alpha_w = $signed(th_w - hd_q);
  assign beta_w  = $signed(16'd0 - goal_heading_i - alpha_w);

  // radian conversion of the gain sum
  logic signed [58:0] nr_prod_w;
  logic signed [43:0] nr_w;
  logic        [43:0] nr_abs_w;
  logic        [19:0] kr_abs_w;
  assign nr_prod_w = 59'(n_q) * 59'sd205887 + 59'sd16384;
  assign nr_w      = 44'(nr_prod_w >>> 15);
  assign nr_abs_w  = nr_w[43] ? 44'(-nr_w) : nr_w;
  assign kr_abs_w  = gain_distance_i[19] ? 20'(-gain_distance_i) : gain_distance_i;

  // restoring divide step
  logic [64:0] shf_w;
  assign shf_w = {prem_q[63:0], num_q[63]};

  logic [63:0] q_w;
  assign q_w = quo_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pgps_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      pgps_pkg::BK_IDLE: begin
        if (in_valid_i) begin
          pop_o   = 1'b1;
          state_d = in_item_i.arrived ? pgps_pkg::BK_OUT : pgps_pkg::BK_RUN;
        end
      end
      pgps_pkg::BK_RUN: if (cnt_q == 6'(pgps_pkg::CordicIters - 1)) state_d = pgps_pkg::BK_MUL;
      pgps_pkg::BK_MUL: if (cnt_q == 6'd2) state_d = pgps_pkg::BK_DIV;
      pgps_pkg::BK_DIV: if (cnt_q == 6'd63) state_d = pgps_pkg::BK_OUT;
      pgps_pkg::BK_OUT: state_d = pgps_pkg::BK_IDLE;
      default: state_d = pgps_pkg::BK_IDLE;
    endcase
  end

  assign idle_o = (state_q == pgps_pkg::BK_IDLE);

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      pgps_pkg::BK_IDLE: begin
        cnt_q     <= '0;
        arrived_o <= in_item_i.arrived;
        rem_q     <= in_item_i.sum_sq;
        root_q    <= '0;
        bit_q     <= 52'd1 << 48;
        hd_q      <= in_item_i.heading;
        if (in_item_i.dx < 0) begin
          cx_q <= -($signed(59'(in_item_i.dx)) <<< 32);
          cy_q <= -($signed(59'(in_item_i.dy)) <<< 32);
          cz_q <= 32'h80000000;
        end else begin
          cx_q <= $signed(59'(in_item_i.dx)) <<< 32;
          cy_q <= $signed(59'(in_item_i.dy)) <<< 32;
          cz_q <= '0;
        end
      end
      pgps_pkg::BK_RUN: begin
        cnt_q <= (cnt_q == 6'(pgps_pkg::CordicIters - 1)) ? '0 : cnt_q + 6'd1;
        // cordic rotation
        if (cy_q >= 0) begin
          cx_q <= cx_q + ys_w;
          cy_q <= cy_q - xs_w;
          cz_q <= cz_q + pgps_pkg::atan_lut(cnt_q[4:0]);
        end else begin
          cx_q <= cx_q - ys_w;
          cy_q <= cy_q + xs_w;
          cz_q <= cz_q - pgps_pkg::atan_lut(cnt_q[4:0]);
        end
        // one root bit per step, 25 steps fit in the cordic run
        if (bit_q != '0) begin
          if ({2'd0, rem_q} >= trial_w) begin
            rem_q  <= 50'({2'd0, rem_q} - trial_w);
            root_q <= (root_q >> 1) + 50'(bit_q);
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
      pgps_pkg::BK_MUL: begin
        if (cnt_q == 6'd0) begin
          cnt_q <= 6'd1;
          n_q <= 39'(gain_bearing_i * alpha_w) + 39'(gain_final_i * beta_w);
          d_q <= 46'(kr_abs_w) * 46'(root_q[25:0]);
        end else if (cnt_q == 6'd1) begin
          // radian scaling and magnitude
          cnt_q <= 6'd2;
          neg_q <= nr_w[43];
          nra_q <= nr_abs_w;
        end else begin
          cnt_q  <= '0;
          m_q    <= 64'(nra_q) * 64'(max_speed_i);
          num_q  <= 64'(nra_q) * 64'(max_speed_i) + 64'(d_q >> 1);
          prem_q <= '0;
          quo_q  <= '0;
        end
      end
      pgps_pkg::BK_DIV: begin
        cnt_q <= cnt_q + 6'd1;
        num_q <= num_q << 1;
        if (shf_w >= {19'd0, d_q}) begin
          prem_q <= shf_w - {19'd0, d_q};
          quo_q  <= {quo_q[62:0], 1'b1};
        end else begin
          prem_q <= shf_w;
          quo_q  <= {quo_q[62:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == pgps_pkg::BK_OUT);
    end
  end
  always_ff @(posedge clk_i) begin
    if (state_q == pgps_pkg::BK_OUT) begin
      if (arrived_o) begin
        linear_speed_o <= '0;
        angular_rate_o <= '0;
      end else begin
        if (gain_distance_i > 0)      linear_speed_o <= $signed({1'b0, max_speed_i});
        else if (gain_distance_i < 0) linear_speed_o <= -$signed({1'b0, max_speed_i});
        else                          linear_speed_o <= '0;
        if (d_q == '0) begin
          angular_rate_o <= (m_q == '0) ? 22'sd0 : (neg_q ? pgps_pkg::AngMin : pgps_pkg::AngMax);
        end else if (q_w > 64'd2097151) begin
          angular_rate_o <= neg_q ? pgps_pkg::AngMin : pgps_pkg::AngMax;
        end else begin
          angular_rate_o <= neg_q ? -$signed(22'(q_w)) : $signed(22'(q_w));
        end
      end
    end
  end

endmodule
`default_nettype wire
